/* rtl/bpa_pkg.sv */
// Shared types and constants of the buddy page allocator.
package bpa_pkg;

	localparam logic [3:0] MARK_ALLOC    = 4'd14;
	localparam logic [3:0] MARK_INTERIOR = 4'd15;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_MEMORY = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE = 2'd2;
	localparam logic [1:0] ST_NOT_HEAD  = 2'd3;

	typedef struct packed {
		logic       too_large;
		logic [3:0] order;
	} size_res_t;

endpackage

/* rtl/bpa_size_order.sv */
// Rounds a byte count up to the smallest block order that holds it.
module bpa_size_order import bpa_pkg::*; #(
	parameter int TOP_ORDER  = 6,
	parameter int PAGE_BYTES = 4096
) (
	input  logic [23:0] request_bytes,
	output size_res_t   res
);

	always_comb begin
		res.too_large = (64'(request_bytes) > (64'(PAGE_BYTES) << TOP_ORDER));
		res.order     = 4'(TOP_ORDER);
		// Each order is compared on its own; the lowest order that fits wins.
		for (int r = TOP_ORDER; r >= 0; r--) begin
			if (64'(request_bytes) <= (64'(PAGE_BYTES) << r)) begin
				res.order = 4'(r);
			end
		end
	end

endmodule

/* rtl/buddy_page_allocator.sv */
// Top level of the buddy page allocator: sequencer, frame memories and free lists.
//
// Usage. A command beat is taken at a rising clock edge where start is high and
// busy is low: action 0 allocates request_bytes, action 1 frees the block whose
// head frame is page_index. Exactly one result beat follows for every command:
// done is high for one cycle while status, granted_index, granted_address and
// granted_order hold the result. The receiver cannot stall, so results are
// never held back. One command is worked at a time; busy drops with done, so the
// next command can be taken at the edge that takes the result.
// An error on size or memory is answered from the idle state, as is a free of an
// index outside the pool; a free that is not a block head is answered once its
// frame marker has been read. The pace of the work is set by the single read
// port of each frame memory: every list link update is a read followed by a
// write in the next state, done strictly in turn, so no access overlaps a
// pending write. Reset: arst_n low clears the sequencer and loads the free list
// head and tail registers with the top-order list of whole blocks, then a
// clearing pass writes every frame entry with busy high. The pool base register
// (wr_en, wr_data) should change only while idle.
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int PAGES      = 1024,
	parameter int TOP_ORDER  = 6,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        action,
	input  logic [23:0] request_bytes,
	input  logic [9:0]  page_index,
	output logic [1:0]  status,
	output logic [9:0]  granted_index,
	output logic [32:0] granted_address,
	output logic [2:0]  granted_order,
	input  logic        wr_en,
	input  logic [31:0] wr_data
);

	localparam int IW   = $clog2(PAGES);
	localparam int LW   = $clog2(PAGES + 1);
	localparam int OW   = (TOP_ORDER < 2) ? 1 : $clog2(TOP_ORDER + 1);
	localparam int BLK  = 1 << TOP_ORDER;
	localparam int NBLK = PAGES / BLK;
	localparam logic [LW-1:0] NIL = LW'(PAGES);

	typedef enum logic [4:0] {
		INIT, IDLE,
		A_SPLIT, A_LO, A_HI, A_FIN,
		F_CHK, F_LOOP, F_BCHK, F_MERGE, F_END, F_FIN,
		RM_RD, RM_GOT, RM_P, RM_PW, RM_N, RM_NW,
		AP_ST, AP_W
	} state_t;

	state_t          state_q, ret_q;
	logic [IW:0]     init_cnt_q;
	logic [31:0]     base_q;
	logic [LW-1:0]   head_q [TOP_ORDER+1];
	logic [LW-1:0]   tail_q [TOP_ORDER+1];
	logic [OW-1:0]   a_q, req_q, ord_q, lord_q;
	logic [IW-1:0]   idx_q, bud_q, lx_q;
	logic [LW-1:0]   n_q, p_q, t_q;
	logic            done_q;
	logic [1:0]      status_q;
	logic [9:0]      gidx_q;
	logic [32:0]     gaddr_q;
	logic [2:0]      gord_q;

	// Frame memories: marker and alloc info in one, next and prev links in the other.
	logic [7:0]      m_mem [PAGES];
	logic [2*LW-1:0] l_mem [PAGES];
	logic            m_we, l_we;
	logic [IW-1:0]   m_waddr, m_raddr, l_waddr, l_raddr;
	logic [7:0]      m_wdata, m_rdata;
	logic [2*LW-1:0] l_wdata, l_rdata;

	size_res_t       size_res;
	logic            found;
	logic [OW-1:0]   a_sel;
	logic [IW-1:0]   buddy, half;
	logic            buddy_in;
	logic [LW-1:0]   tail_sel, head_sel;
	logic [3:0]      info;
	logic [IW+16:0]  product;
	logic [31:0]     ic;
	logic            init_head;
	logic [LW-1:0]   init_next, init_prev;

	bpa_size_order #(
		.TOP_ORDER (TOP_ORDER),
		.PAGE_BYTES(PAGE_BYTES)
	) u_size (
		.request_bytes(request_bytes),
		.res          (size_res)
	);

	always_ff @(posedge clk) begin
		if (m_we) begin
			m_mem[m_waddr] <= m_wdata;
		end
		m_rdata <= m_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			l_mem[l_waddr] <= l_wdata;
		end
		l_rdata <= l_mem[l_raddr];
	end

	// Search for the first nonempty list at or above the requested order.
	always_comb begin
		found = 1'b0;
		a_sel = '0;
		for (int r = TOP_ORDER; r >= 0; r--) begin
			if (r >= int'(size_res.order) && head_q[r] != NIL) begin
				found = 1'b1;
				a_sel = OW'(r);
			end
		end
	end

	assign buddy    = idx_q ^ (IW'(1) << ord_q);
	assign buddy_in = {1'b0, buddy} < (IW+1)'(PAGES);
	assign half     = idx_q + (IW'(1) << (a_q - OW'(1)));
	assign tail_sel = tail_q[lord_q];
	assign head_sel = head_q[a_q];
	assign info     = m_rdata[3:0];
	assign product  = (IW+17)'(idx_q) * (IW+17)'(PAGE_BYTES);

	// Reset image of one frame for the clearing pass.
	always_comb begin
		ic        = 32'(init_cnt_q);
		init_head = ((ic & 32'(BLK - 1)) == 32'd0) && (ic + 32'(BLK) <= 32'(PAGES));
		init_next = NIL;
		init_prev = NIL;
		if (init_head) begin
			if (ic + 32'(2 * BLK) <= 32'(PAGES)) begin
				init_next = LW'(ic + 32'(BLK));
			end
			if (ic != 32'd0) begin
				init_prev = LW'(ic - 32'(BLK));
			end
		end
	end

	// Memory port control follows the sequencer state.
	always_comb begin
		m_we    = 1'b0;
		m_waddr = idx_q;
		m_wdata = {MARK_INTERIOR, 4'd0};
		m_raddr = IW'(page_index);
		l_we    = 1'b0;
		l_waddr = lx_q;
		l_wdata = {NIL, NIL};
		l_raddr = lx_q;
		unique case (state_q)
			INIT: begin
				m_we    = 1'b1;
				m_waddr = init_cnt_q[IW-1:0];
				m_wdata = {(init_head ? 4'(TOP_ORDER) : MARK_INTERIOR), 4'd0};
				l_we    = 1'b1;
				l_waddr = init_cnt_q[IW-1:0];
				l_wdata = {init_next, init_prev};
			end
			A_LO: begin
				m_we    = 1'b1;
				m_wdata = {4'(a_q - OW'(1)), 4'd0};
			end
			A_HI: begin
				m_we    = 1'b1;
				m_waddr = half;
				m_wdata = {4'(a_q - OW'(1)), 4'd0};
			end
			A_FIN: begin
				m_we    = 1'b1;
				m_wdata = {MARK_ALLOC, 4'(req_q) + 4'd1};
			end
			F_CHK: begin
				m_we = (info != 4'd0) && (info <= 4'(TOP_ORDER + 1));
			end
			F_LOOP: begin
				m_raddr = buddy;
			end
			F_MERGE: begin
				m_we    = 1'b1;
				m_waddr = bud_q;
			end
			F_END: begin
				m_we    = 1'b1;
				m_wdata = {4'(ord_q), 4'd0};
			end
			RM_GOT: begin
				l_we = 1'b1;
			end
			RM_P: begin
				l_raddr = p_q[IW-1:0];
			end
			RM_PW: begin
				l_we    = 1'b1;
				l_waddr = p_q[IW-1:0];
				l_wdata = {n_q, l_rdata[LW-1:0]};
			end
			RM_N: begin
				l_raddr = n_q[IW-1:0];
			end
			RM_NW: begin
				l_we    = 1'b1;
				l_waddr = n_q[IW-1:0];
				l_wdata = {l_rdata[2*LW-1:LW], p_q};
			end
			AP_ST: begin
				l_we    = 1'b1;
				l_wdata = {NIL, tail_sel};
				l_raddr = tail_sel[IW-1:0];
			end
			AP_W: begin
				l_we    = 1'b1;
				l_waddr = t_q[IW-1:0];
				l_wdata = {LW'(lx_q), l_rdata[LW-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (wr_en) begin
			base_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= INIT;
			ret_q      <= IDLE;
			init_cnt_q <= '0;
			done_q     <= 1'b0;
			for (int i = 0; i <= TOP_ORDER; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
			head_q[TOP_ORDER] <= (NBLK > 0) ? LW'(0) : NIL;
			tail_q[TOP_ORDER] <= (NBLK > 0) ? LW'((NBLK - 1) * BLK) : NIL;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				INIT: begin
					init_cnt_q <= init_cnt_q + (IW+1)'(1);
					if (init_cnt_q == (IW+1)'(PAGES - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (start) begin
						status_q <= ST_OK;
						gidx_q   <= '0;
						gaddr_q  <= '0;
						gord_q   <= '0;
						idx_q    <= IW'(page_index);
						req_q    <= OW'(size_res.order);
						a_q      <= a_sel;
						if (!action) begin
							if (size_res.too_large) begin
								status_q <= ST_TOO_LARGE;
								done_q   <= 1'b1;
							end else if (!found) begin
								status_q <= ST_NO_MEMORY;
								done_q   <= 1'b1;
							end else begin
								state_q <= A_SPLIT;
							end
						end else if (11'(page_index) >= 11'(PAGES)) begin
							status_q <= ST_NOT_HEAD;
							done_q   <= 1'b1;
						end else begin
							state_q <= F_CHK;
						end
					end
				end
				A_SPLIT: begin
					lx_q    <= head_sel[IW-1:0];
					idx_q   <= head_sel[IW-1:0];
					lord_q  <= a_q;
					ret_q   <= (a_q > req_q) ? A_LO : A_FIN;
					state_q <= RM_RD;
				end
				A_LO: begin
					lx_q    <= idx_q;
					lord_q  <= a_q - OW'(1);
					ret_q   <= A_HI;
					state_q <= AP_ST;
				end
				A_HI: begin
					lx_q    <= half;
					a_q     <= a_q - OW'(1);
					ret_q   <= A_SPLIT;
					state_q <= AP_ST;
				end
				A_FIN: begin
					gidx_q  <= 10'(idx_q);
					gaddr_q <= 33'(base_q) + 33'(product);
					gord_q  <= 3'(req_q);
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				F_CHK: begin
					if (info == 4'd0 || info > 4'(TOP_ORDER + 1)) begin
						status_q <= ST_NOT_HEAD;
						done_q   <= 1'b1;
						state_q  <= IDLE;
					end else begin
						ord_q   <= OW'(info - 4'd1);
						state_q <= F_LOOP;
					end
				end
				F_LOOP: begin
					bud_q   <= buddy;
					state_q <= (int'(ord_q) < TOP_ORDER && buddy_in) ? F_BCHK : F_END;
				end
				F_BCHK: begin
					if (m_rdata[7:4] == 4'(ord_q)) begin
						lx_q    <= bud_q;
						lord_q  <= ord_q;
						ret_q   <= F_MERGE;
						state_q <= RM_RD;
					end else begin
						state_q <= F_END;
					end
				end
				F_MERGE: begin
					if (bud_q < idx_q) begin
						idx_q <= bud_q;
					end
					ord_q   <= ord_q + OW'(1);
					state_q <= F_LOOP;
				end
				F_END: begin
					lx_q    <= idx_q;
					lord_q  <= ord_q;
					ret_q   <= F_FIN;
					state_q <= AP_ST;
				end
				F_FIN: begin
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				RM_RD: begin
					state_q <= RM_GOT;
				end
				RM_GOT: begin
					n_q     <= l_rdata[2*LW-1:LW];
					p_q     <= l_rdata[LW-1:0];
					state_q <= RM_P;
				end
				RM_P: begin
					if (p_q != NIL) begin
						state_q <= RM_PW;
					end else begin
						head_q[lord_q] <= n_q;
						state_q        <= RM_N;
					end
				end
				RM_PW: begin
					state_q <= RM_N;
				end
				RM_N: begin
					if (n_q != NIL) begin
						state_q <= RM_NW;
					end else begin
						tail_q[lord_q] <= p_q;
						state_q        <= ret_q;
					end
				end
				RM_NW: begin
					state_q <= ret_q;
				end
				AP_ST: begin
					t_q            <= tail_sel;
					tail_q[lord_q] <= LW'(lx_q);
					if (tail_sel != NIL) begin
						state_q <= AP_W;
					end else begin
						head_q[lord_q] <= LW'(lx_q);
						state_q        <= ret_q;
					end
				end
				AP_W: begin
					state_q <= ret_q;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign granted_index   = gidx_q;
	assign granted_address = gaddr_q;
	assign granted_order   = gord_q;

`ifndef ASSERT_OFF
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result beat without a command in progress");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |->
		(granted_index == 10'd0 && granted_address == 33'd0 && granted_order == 3'd0))
		else $error("granted fields not zero on a failed command");
	a_cmd_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither worked nor answered");
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(granted_order) <= TOP_ORDER))
		else $error("granted order above the top order");
`endif

endmodule
